// ===== sv/ngga_pkg.sv =====
// ngga_pkg: shared constants, types and helpers of the gga position parser
// no dependencies; used by ngga_field and nmea_gga_position_parser_top
`default_nettype none

package ngga_pkg;

  // character codes
  localparam logic [7:0] CH_DOLLAR  = 8'd36;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_POINT   = 8'd46;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_G       = 8'd71;
  localparam logic [7:0] CH_A       = 8'd65;

  // kept windows of the line
  localparam int unsigned TYPE_POS = 3;
  localparam int unsigned TYPE_LEN = 3;
  localparam int unsigned LAT_POS  = 18;
  localparam int unsigned LAT_LEN  = 9;
  localparam int unsigned LON_POS  = 30;
  localparam int unsigned LON_LEN  = 10;

  // result widths and limits
  localparam int unsigned LAT_DEG_W   = 7;
  localparam int unsigned LON_DEG_W   = 10;
  localparam int unsigned LAT_DEG_MAX = 99;
  localparam int unsigned LON_DEG_MAX = 999;
  localparam int unsigned MIN_W       = 7;
  localparam int unsigned SEC_W       = 6;

  // fraction kept as four decimal digits, seconds = frac * 60 / 10000
  localparam int unsigned FRAC_W      = 14;
  localparam int unsigned FRAC_DIGITS = 4;
  localparam int unsigned FRAC_ONE    = 10000;
  localparam int unsigned SEC_PER_MIN = 60;
  localparam int unsigned REM_W       = 20;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_CHECK,
    TS_PARSE
  } top_state_e;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_SCAN,
    FS_LOAD,
    FS_DIV,
    FS_DONE
  } fld_state_e;

  typedef enum logic [1:0] {
    FP_INT,
    FP_FRAC,
    FP_STOP
  } fld_phase_e;

  typedef struct packed {
    logic done;
    logic over;
  } fld_stat_t;

  // weight of a fraction digit by its place after the point
  function automatic logic [FRAC_W-1:0] frac_place(input logic [1:0] place);
    logic [FRAC_W-1:0] w;
    case (place)
      2'd0:    w = FRAC_W'(1000);
      2'd1:    w = FRAC_W'(100);
      2'd2:    w = FRAC_W'(10);
      default: w = FRAC_W'(1);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ngga_field.sv =====
// ngga_field: one kept coordinate window and its serial ddmm.ffff parser
// depends on ngga_pkg
`default_nettype none

module ngga_field #(
  parameter int unsigned LEN     = 9,
  parameter int unsigned DEG_W   = 7,
  parameter int unsigned DEG_MAX = 99
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic [$clog2(LEN)-1:0]        wr_idx_i,
  input  wire logic [7:0]                    wr_data_i,
  input  wire logic                          start_i,
  output ngga_pkg::fld_stat_t                stat_o,
  output logic      [DEG_W-1:0]              deg_o,
  output logic      [ngga_pkg::MIN_W-1:0]    min_o,
  output logic      [ngga_pkg::SEC_W-1:0]    sec_o
);

  localparam int unsigned IdxW  = $clog2(LEN);
  localparam int unsigned DegXW = DEG_W + 4;
  localparam int unsigned MinW  = ngga_pkg::MIN_W;
  localparam int unsigned SecW  = ngga_pkg::SEC_W;
  localparam int unsigned FracW = ngga_pkg::FRAC_W;
  localparam int unsigned RemW  = ngga_pkg::REM_W;

  logic [7:0] win_q [LEN];

  ngga_pkg::fld_state_e state_q, state_d;
  ngga_pkg::fld_phase_e phase_q, phase_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;
  logic [DEG_W-1:0] deg_q, deg_d;
  logic [MinW-1:0]  min_q, min_d;
  logic [FracW-1:0] frac_q, frac_d;
  logic [2:0]       fd_q, fd_d;
  logic             over_q, over_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [2:0]       divk_q, divk_d;
  logic [SecW-1:0]  sec_q, sec_d;
  logic             rotate;

  logic [7:0]       head;
  logic             is_dig;
  logic [3:0]       dig;
  logic [9:0]       t_val;
  logic [3:0]       carry;
  logic [DegXW-1:0] new_deg;
  logic [RemW-1:0]  trial;
  logic             ge;

  assign head   = win_q[0];
  assign is_dig = head inside {[ngga_pkg::CH_ZERO:ngga_pkg::CH_NINE]};
  assign dig    = 4'(head - ngga_pkg::CH_ZERO);

  // append one integer digit: ipart*10+d split as deg*100+min
  always_comb begin
    t_val = 10'(min_q) * 10'd10 + 10'(dig);
    carry = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (t_val >= 10'(k * 100)) carry = 4'(k);
    end
    new_deg = DegXW'(deg_q) * DegXW'(10) + DegXW'(carry);
  end

  assign trial = RemW'(ngga_pkg::FRAC_ONE) << divk_q;
  assign ge    = (rem_q >= trial);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    deg_d   = deg_q;
    min_d   = min_q;
    frac_d  = frac_q;
    fd_d    = fd_q;
    over_d  = over_q;
    rem_d   = rem_q;
    divk_d  = divk_q;
    sec_d   = sec_q;
    rotate  = 1'b0;
    case (state_q)
      ngga_pkg::FS_IDLE, ngga_pkg::FS_DONE: begin
        if (start_i) begin
          state_d = ngga_pkg::FS_SCAN;
          phase_d = ngga_pkg::FP_INT;
          cnt_d   = '0;
          deg_d   = '0;
          min_d   = '0;
          frac_d  = '0;
          fd_d    = '0;
          over_d  = 1'b0;
          sec_d   = '0;
        end
      end
      ngga_pkg::FS_SCAN: begin
        rotate = 1'b1;
        case (phase_q)
          ngga_pkg::FP_INT: begin
            if (is_dig) begin
              if (!over_q) begin
                if (new_deg > DegXW'(DEG_MAX)) begin
                  over_d = 1'b1;
                end else begin
                  deg_d = DEG_W'(new_deg);
                  min_d = MinW'(t_val - 10'(carry) * 10'd100);
                end
              end
            end else if (head == ngga_pkg::CH_POINT) begin
              phase_d = ngga_pkg::FP_FRAC;
            end else begin
              phase_d = ngga_pkg::FP_STOP;
            end
          end
          ngga_pkg::FP_FRAC: begin
            if (is_dig) begin
              if (fd_q < 3'(ngga_pkg::FRAC_DIGITS)) begin
                frac_d = frac_q + FracW'(dig) * ngga_pkg::frac_place(fd_q[1:0]);
                fd_d   = fd_q + 3'd1;
              end
            end else begin
              phase_d = ngga_pkg::FP_STOP;
            end
          end
          default: ;
        endcase
        if (cnt_q == IdxW'(LEN - 1)) begin
          state_d = ngga_pkg::FS_LOAD;
        end else begin
          cnt_d = cnt_q + IdxW'(1);
        end
      end
      ngga_pkg::FS_LOAD: begin
        // frac * 60 as frac*64 - frac*4
        rem_d   = (RemW'(frac_q) << 6) - (RemW'(frac_q) << 2);
        divk_d  = 3'(SecW - 1);
        state_d = ngga_pkg::FS_DIV;
      end
      ngga_pkg::FS_DIV: begin
        // restoring division by 10000, one quotient bit a cycle
        if (ge) rem_d = rem_q - trial;
        sec_d = {sec_q[SecW-2:0], ge};
        if (divk_q == 3'd0) begin
          state_d = ngga_pkg::FS_DONE;
        end else begin
          divk_d = divk_q - 3'd1;
        end
      end
      default: state_d = ngga_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ngga_pkg::FS_IDLE;
      phase_q <= ngga_pkg::FP_STOP;
      cnt_q   <= '0;
      over_q  <= 1'b0;
      divk_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      over_q  <= over_d;
      divk_q  <= divk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    deg_q  <= deg_d;
    min_q  <= min_d;
    frac_q <= frac_d;
    fd_q   <= fd_d;
    rem_q  <= rem_d;
    sec_q  <= sec_d;
  end

  // window: rotates by one per scan step, full turn restores it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEN; i++) win_q[i] <= 8'd0;
    end else if (rotate) begin
      for (int i = 0; i < LEN - 1; i++) win_q[i] <= win_q[i+1];
      win_q[LEN-1] <= win_q[0];
    end else if (wr_en_i) begin
      win_q[wr_idx_i] <= wr_data_i;
    end
  end

  assign stat_o.done = (state_q == ngga_pkg::FS_DONE);
  assign stat_o.over = over_q;
  assign deg_o       = deg_q;
  assign min_o       = min_q;
  assign sec_o       = sec_q;

endmodule

`default_nettype wire

// ===== sv/nmea_gga_position_parser_top.sv =====
// nmea_gga_position_parser_top: gga latitude/longitude extraction from a byte stream
// depends on ngga_pkg and ngga_field
//
// input channel: one received character word (rx_byte_i) per in_valid_i/in_ready_o
// handshake. every word is stored at the current line position; only the type,
// latitude and longitude windows are kept. '$' restarts the line, newline ends it.
// output channel: one result word per out_valid_o/out_ready_i handshake, made only
// when a newline closes a line whose type window holds "GGA".
// flow: an ordinary word is taken whenever input ready is high. after a newline, input
// ready drops for the type check and comes back if the type is not gga; otherwise the
// line is parsed in order (type check, digit-serial window scan, multiply by 60,
// bit-serial division for seconds, output load), and input ready returns when the
// result is loaded.
// stall: a finished result sits in the output register while new words are taken;
// the next result waits in the parsers until the output register frees up.
// reset: line position and all windows clear to zero, no result pending.
`default_nettype none

module nmea_gga_position_parser_top #(
  parameter int unsigned LINE_LIMIT = 100
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [6:0]       lat_degrees_o,
  output logic [6:0]       lat_minutes_o,
  output logic [5:0]       lat_seconds_o,
  output logic [9:0]       lon_degrees_o,
  output logic [6:0]       lon_minutes_o,
  output logic [5:0]       lon_seconds_o,
  output logic             malformed_o
);

  localparam int unsigned LatIdxW  = $clog2(ngga_pkg::LAT_LEN);
  localparam int unsigned LonIdxW  = $clog2(ngga_pkg::LON_LEN);
  localparam int unsigned TypeIdxW = $clog2(ngga_pkg::TYPE_LEN);

  ngga_pkg::top_state_e state_q, state_d;

  logic [6:0] pos_q, pos_d;
  logic [7:0] type_q [ngga_pkg::TYPE_LEN];

  logic acc;
  logic type_we, lat_we, lon_we;
  logic is_gga;
  logic start;
  logic out_load;
  logic out_valid_q;

  ngga_pkg::fld_stat_t lat_stat, lon_stat;
  logic [6:0] lat_deg, lat_min, lon_min;
  logic [9:0] lon_deg;
  logic [5:0] lat_sec, lon_sec;
  logic       mal;

  assign in_ready_o = (state_q == ngga_pkg::TS_IDLE);
  assign acc        = in_valid_i && in_ready_o;

  // window decode from the position before this word
  assign type_we = acc && (pos_q >= 7'(ngga_pkg::TYPE_POS))
                       && (pos_q <  7'(ngga_pkg::TYPE_POS + ngga_pkg::TYPE_LEN));
  assign lat_we  = acc && (pos_q >= 7'(ngga_pkg::LAT_POS))
                       && (pos_q <  7'(ngga_pkg::LAT_POS + ngga_pkg::LAT_LEN));
  assign lon_we  = acc && (pos_q >= 7'(ngga_pkg::LON_POS))
                       && (pos_q <  7'(ngga_pkg::LON_POS + ngga_pkg::LON_LEN));

  // position update: '$' restarts at 1, newline returns to 0, else saturating step
  always_comb begin
    pos_d = pos_q;
    if (acc) begin
      if (rx_byte_i == ngga_pkg::CH_DOLLAR) begin
        pos_d = 7'd1;
      end else if (rx_byte_i == ngga_pkg::CH_NEWLINE) begin
        pos_d = 7'd0;
      end else if (pos_q >= 7'(LINE_LIMIT)) begin
        pos_d = 7'(LINE_LIMIT);
      end else begin
        pos_d = pos_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 7'd0;
      for (int i = 0; i < ngga_pkg::TYPE_LEN; i++) type_q[i] <= 8'd0;
    end else begin
      pos_q <= pos_d;
      if (type_we) type_q[TypeIdxW'(pos_q - 7'(ngga_pkg::TYPE_POS))] <= rx_byte_i;
    end
  end

  assign is_gga = (type_q[0] == ngga_pkg::CH_G) && (type_q[1] == ngga_pkg::CH_G)
               && (type_q[2] == ngga_pkg::CH_A);

  // control: idle takes words, check tests the type, parse waits for both fields and a free output register
  always_comb begin
    state_d  = state_q;
    start    = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ngga_pkg::TS_IDLE: begin
        if (acc && rx_byte_i == ngga_pkg::CH_NEWLINE) state_d = ngga_pkg::TS_CHECK;
      end
      ngga_pkg::TS_CHECK: begin
        if (is_gga) begin
          start   = 1'b1;
          state_d = ngga_pkg::TS_PARSE;
        end else begin
          state_d = ngga_pkg::TS_IDLE;
        end
      end
      ngga_pkg::TS_PARSE: begin
        if (lat_stat.done && lon_stat.done && (!out_valid_q || out_ready_i)) begin
          out_load = 1'b1;
          state_d  = ngga_pkg::TS_IDLE;
        end
      end
      default: state_d = ngga_pkg::TS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ngga_pkg::TS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  ngga_field #(
    .LEN     (ngga_pkg::LAT_LEN),
    .DEG_W   (ngga_pkg::LAT_DEG_W),
    .DEG_MAX (ngga_pkg::LAT_DEG_MAX)
  ) u_lat (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (lat_we),
    .wr_idx_i  (LatIdxW'(pos_q - 7'(ngga_pkg::LAT_POS))),
    .wr_data_i (rx_byte_i),
    .start_i   (start),
    .stat_o    (lat_stat),
    .deg_o     (lat_deg),
    .min_o     (lat_min),
    .sec_o     (lat_sec)
  );

  ngga_field #(
    .LEN     (ngga_pkg::LON_LEN),
    .DEG_W   (ngga_pkg::LON_DEG_W),
    .DEG_MAX (ngga_pkg::LON_DEG_MAX)
  ) u_lon (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (lon_we),
    .wr_idx_i  (LonIdxW'(pos_q - 7'(ngga_pkg::LON_POS))),
    .wr_data_i (rx_byte_i),
    .start_i   (start),
    .stat_o    (lon_stat),
    .deg_o     (lon_deg),
    .min_o     (lon_min),
    .sec_o     (lon_sec)
  );

  // an oversized integer part in either field zeroes the whole result
  assign mal = lat_stat.over | lon_stat.over;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      lat_degrees_o <= mal ? 7'd0  : lat_deg;
      lat_minutes_o <= mal ? 7'd0  : lat_min;
      lat_seconds_o <= mal ? 6'd0  : lat_sec;
      lon_degrees_o <= mal ? 10'd0 : lon_deg;
      lon_minutes_o <= mal ? 7'd0  : lon_min;
      lon_seconds_o <= mal ? 6'd0  : lon_sec;
      malformed_o   <= mal;
    end
  end

  assign out_valid_o = out_valid_q;

  a_pos_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 7'(LINE_LIMIT))
    else $error("line position beyond limit");

  a_newline_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && rx_byte_i == ngga_pkg::CH_NEWLINE |=> state_q == ngga_pkg::TS_CHECK)
    else $error("newline did not start the type check");

  a_mal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && malformed_o |-> lat_degrees_o == 7'd0 && lat_minutes_o == 7'd0
      && lat_seconds_o == 6'd0 && lon_degrees_o == 10'd0 && lon_minutes_o == 7'd0
      && lon_seconds_o == 6'd0)
    else $error("malformed result carries values");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> lat_seconds_o < 6'd60 && lon_seconds_o < 6'd60
      && lat_minutes_o < 7'd100 && lon_minutes_o < 7'd100)
    else $error("minutes or seconds out of range");

endmodule

`default_nettype wire
